FILE: hw/rtl/fft2_pkg.sv
// ----------------------------------------------------------------------------
// fft2_pkg
// Shared constants and controller command type for the radix-2 butterfly stage.
// ----------------------------------------------------------------------------
package fft2_pkg;

   // twiddle format is Q1.15 independent of the sample width
   localparam int TW_BITS = 16;

   // pi/2 in Q61, 1/sqrt2 in Q63, 1.0 in Q61
   localparam logic [63:0] PI_HALF_Q61   = 64'h3243F6A8885A308D;
   localparam logic [63:0] INV_SQRT2_Q63 = 64'h5A827999FCEF3242;
   localparam logic [63:0] Q61_ONE       = 64'h2000000000000000;

   // Taylor series divisors: sin term 2i*(2i+1), cos term (2i-1)*2i
   localparam int TAYLOR_TERMS = 24;
   localparam logic [11:0] SIN_DIV [TAYLOR_TERMS] = '{
      12'd6,    12'd20,   12'd42,   12'd72,   12'd110,  12'd156,
      12'd210,  12'd272,  12'd342,  12'd420,  12'd506,  12'd600,
      12'd702,  12'd812,  12'd930,  12'd1056, 12'd1190, 12'd1332,
      12'd1482, 12'd1640, 12'd1806, 12'd1980, 12'd2162, 12'd2352
   };
   localparam logic [11:0] COS_DIV [TAYLOR_TERMS] = '{
      12'd2,    12'd12,   12'd30,   12'd56,   12'd90,   12'd132,
      12'd182,  12'd240,  12'd306,  12'd380,  12'd462,  12'd552,
      12'd650,  12'd756,  12'd870,  12'd992,  12'd1122, 12'd1260,
      12'd1406, 12'd1560, 12'd1722, 12'd1892, 12'd2070, 12'd2256
   };

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture word, read twiddle, step index
      logic mult;      // b * W partial products
      logic sum;       // a +/- bW
      logic scale;     // times 1/sqrt2
      logic out_load;  // round, saturate, fill output register
   } cmd_type;

endpackage

FILE: hw/rtl/fft2_if.sv
// ----------------------------------------------------------------------------
// fft2 channel interfaces
// Valid/ready channels for the butterfly input pair and the result pair.
// ----------------------------------------------------------------------------
interface fft2_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] a_real;
   logic signed [SAMPLE_BITS-1:0] a_imag;
   logic signed [SAMPLE_BITS-1:0] b_real;
   logic signed [SAMPLE_BITS-1:0] b_imag;
   logic                          frame_last;

   modport source (
      output valid, a_real, a_imag, b_real, b_imag, frame_last,
      input  ready
   );
   modport sink (
      input  valid, a_real, a_imag, b_real, b_imag, frame_last,
      output ready
   );
endinterface

interface fft2_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sum_real;
   logic signed [SAMPLE_BITS-1:0] sum_imag;
   logic signed [SAMPLE_BITS-1:0] diff_real;
   logic signed [SAMPLE_BITS-1:0] diff_imag;
   logic                          out_last;

   modport source (
      output valid, sum_real, sum_imag, diff_real, diff_imag, out_last,
      input  ready
   );
   modport sink (
      input  valid, sum_real, sum_imag, diff_real, diff_imag, out_last,
      output ready
   );
endinterface

FILE: hw/rtl/fft2_twiddle_rom.sv
// ----------------------------------------------------------------------------
// fft2_twiddle_rom
// Twiddle ROM, {cos, -sin} of 2*pi*(k mod N)/N in Q1.15, registered read.
// Contents are built at elaboration with a fixed-point Taylor expansion.
// ----------------------------------------------------------------------------
module fft2_twiddle_rom #(
   parameter int TRANSFORM_SIZE  = 1024,
   parameter int TWIDDLE_ENTRIES = 512,
   parameter int ADDR_W          = 9
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [ADDR_W-1:0]               rd_addr,
   output logic [2*fft2_pkg::TW_BITS-1:0]  rd_data
);

   localparam int TW_W  = fft2_pkg::TW_BITS;
   localparam int ROM_W = 2 * TW_W;

   function automatic logic [63:0] mul_q61(input logic [63:0] x, input logic [63:0] y);
      logic [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      return p[124:61];
   endfunction

   function automatic logic signed [63:0] sat_tw(input logic signed [63:0] v);
      logic signed [63:0] r;
      r = v;
      if (v > 64'sd32767) begin
         r = 64'sd32767;
      end
      if (v < -64'sd32768) begin
         r = -64'sd32768;
      end
      return r;
   endfunction

   function automatic logic [ROM_W-1:0] twiddle_entry(input int unsigned k);
      logic [63:0]        p;
      logic [63:0]        quad;
      logic [63:0]        r;
      logic [63:0]        th;
      logic [63:0]        x2;
      logic [63:0]        s;
      logic [63:0]        c;
      logic [63:0]        ts;
      logic [63:0]        tc;
      logic signed [63:0] cm;
      logic signed [63:0] sm;
      logic signed [63:0] cv;
      logic signed [63:0] sv;
      logic signed [63:0] wr;
      logic signed [63:0] wi;
      p    = 64'(k) % TRANSFORM_SIZE;
      quad = (p * 64'd4) / TRANSFORM_SIZE;
      r    = (p * 64'd4) % TRANSFORM_SIZE;
      th   = (fft2_pkg::PI_HALF_Q61 / TRANSFORM_SIZE) * r
           + ((fft2_pkg::PI_HALF_Q61 % TRANSFORM_SIZE) * r) / TRANSFORM_SIZE;
      x2   = mul_q61(th, th);
      s    = th;
      c    = fft2_pkg::Q61_ONE;
      ts   = th;
      tc   = fft2_pkg::Q61_ONE;
      for (int i = 0; i < fft2_pkg::TAYLOR_TERMS; i++) begin
         ts = mul_q61(ts, x2) / 64'(fft2_pkg::SIN_DIV[i]);
         tc = mul_q61(tc, x2) / 64'(fft2_pkg::COS_DIV[i]);
         if (i[0] == 1'b0) begin
            s = s - ts;
            c = c - tc;
         end else begin
            s = s + ts;
            c = c + tc;
         end
      end
      cm = $signed((c + 64'h0000200000000000) >> 46);
      sm = $signed((s + 64'h0000200000000000) >> 46);
      case (quad[1:0])
         2'd0: begin
            cv = cm;
            sv = sm;
         end
         2'd1: begin
            cv = -sm;
            sv = cm;
         end
         2'd2: begin
            cv = -cm;
            sv = -sm;
         end
         default: begin
            cv = sm;
            sv = -cm;
         end
      endcase
      wr = sat_tw(cv);
      wi = sat_tw(-sv);
      return {wr[TW_W-1:0], wi[TW_W-1:0]};
   endfunction

   logic [ROM_W-1:0] rom_table [TWIDDLE_ENTRIES];
   logic [ROM_W-1:0] rd_data_ff;

   for (genvar g = 0; g < TWIDDLE_ENTRIES; g++) begin : g_entry
      localparam logic [ROM_W-1:0] ENTRY = twiddle_entry(g);
      assign rom_table[g] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_table[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fft2_datapath.sv
// ----------------------------------------------------------------------------
// fft2_datapath
// Butterfly datapath: twiddle index, b*W products, sum/difference, 1/sqrt2
// scaling, rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module fft2_datapath #(
   parameter int TRANSFORM_SIZE  = 1024,
   parameter int TWIDDLE_ENTRIES = 512,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fft2_pkg::cmd_type             cmd,
   input  logic signed [SAMPLE_BITS-1:0] a_real,
   input  logic signed [SAMPLE_BITS-1:0] a_imag,
   input  logic signed [SAMPLE_BITS-1:0] b_real,
   input  logic signed [SAMPLE_BITS-1:0] b_imag,
   input  logic                          frame_last,
   output logic signed [SAMPLE_BITS-1:0] sum_real,
   output logic signed [SAMPLE_BITS-1:0] sum_imag,
   output logic signed [SAMPLE_BITS-1:0] diff_real,
   output logic signed [SAMPLE_BITS-1:0] diff_imag,
   output logic                          out_last
);

   localparam int SB     = SAMPLE_BITS;
   localparam int TW_W   = fft2_pkg::TW_BITS;
   localparam int CNT_W  = (TWIDDLE_ENTRIES > 1) ? $clog2(TWIDDLE_ENTRIES) : 1;
   localparam int PP_W   = SB + TW_W;           // b * W partial product
   localparam int V_W    = SB + 17;             // a*2^15 +/- bW, exact
   localparam int SCALE_FRAC = 44 - SB;
   localparam int K_W    = SCALE_FRAC + 1;      // signed 1/sqrt2 constant
   localparam int P_W    = V_W + K_W;           // scaled product
   localparam int OUT_SHIFT = 59 - SB;
   localparam int Q_W    = P_W - OUT_SHIFT;
   localparam logic [63:0] K_RAW =
      ((fft2_pkg::INV_SQRT2_Q63 >> (62 - SCALE_FRAC)) + 64'd1) >> 1;
   localparam logic signed [K_W-1:0] SCALE_K = K_W'(K_RAW);
   localparam logic signed [P_W-1:0] ROUND_BIAS = P_W'(64'd1 << (OUT_SHIFT - 1));
   localparam logic signed [SB-1:0] SAT_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAT_MIN = {1'b1, {(SB-1){1'b0}}};

   function automatic logic signed [SB-1:0] round_sat(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] rnd;
      logic signed [Q_W-1:0] q;
      logic signed [SB-1:0]  r;
      rnd = v + ROUND_BIAS;
      q   = Q_W'(rnd >>> OUT_SHIFT);
      if (q[Q_W-1:SB-1] == {(Q_W-SB+1){1'b0}} || q[Q_W-1:SB-1] == {(Q_W-SB+1){1'b1}}) begin
         r = q[SB-1:0];
      end else if (q[Q_W-1]) begin
         r = SAT_MIN;
      end else begin
         r = SAT_MAX;
      end
      return r;
   endfunction

   logic [CNT_W-1:0]              cnt_ff;
   logic [CNT_W-1:0]              cnt_in;
   logic signed [SB-1:0]          ar_ff, ai_ff, br_ff, bi_ff;
   logic                          last_ff;
   logic [2*TW_W-1:0]             rom_data;
   logic signed [TW_W-1:0]        w_real, w_imag;
   logic signed [PP_W-1:0]        p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [V_W-1:0]         a_rs, a_is, bw_r, bw_i;
   logic signed [V_W-1:0]         s_r_ff, s_i_ff, d_r_ff, d_i_ff;
   logic signed [P_W-1:0]         m_sr_ff, m_si_ff, m_dr_ff, m_di_ff;
   logic signed [SB-1:0]          o_sr_ff, o_si_ff, o_dr_ff, o_di_ff;
   logic                          o_last_ff;

   // twiddle index steps once per accepted word
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         if (frame_last || cnt_ff == CNT_W'(TWIDDLE_ENTRIES - 1)) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   fft2_twiddle_rom #(
      .TRANSFORM_SIZE  (TRANSFORM_SIZE),
      .TWIDDLE_ENTRIES (TWIDDLE_ENTRIES),
      .ADDR_W          (CNT_W)
   ) u_rom (
      .clock   (clock),
      .rd_en   (cmd.load),
      .rd_addr (cnt_ff),
      .rd_data (rom_data)
   );

   assign w_real = rom_data[2*TW_W-1:TW_W];
   assign w_imag = rom_data[TW_W-1:0];

   assign a_rs = {{2{ar_ff[SB-1]}}, ar_ff, 15'd0};
   assign a_is = {{2{ai_ff[SB-1]}}, ai_ff, 15'd0};
   assign bw_r = V_W'(p_rr_ff) - V_W'(p_ii_ff);
   assign bw_i = V_W'(p_ri_ff) + V_W'(p_ir_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ar_ff   <= a_real;
         ai_ff   <= a_imag;
         br_ff   <= b_real;
         bi_ff   <= b_imag;
         last_ff <= frame_last;
      end
      if (cmd.mult) begin
         p_rr_ff <= br_ff * w_real;
         p_ii_ff <= bi_ff * w_imag;
         p_ri_ff <= br_ff * w_imag;
         p_ir_ff <= bi_ff * w_real;
      end
      if (cmd.sum) begin
         s_r_ff <= a_rs + bw_r;
         s_i_ff <= a_is + bw_i;
         d_r_ff <= a_rs - bw_r;
         d_i_ff <= a_is - bw_i;
      end
      if (cmd.scale) begin
         m_sr_ff <= s_r_ff * SCALE_K;
         m_si_ff <= s_i_ff * SCALE_K;
         m_dr_ff <= d_r_ff * SCALE_K;
         m_di_ff <= d_i_ff * SCALE_K;
      end
      if (cmd.out_load) begin
         o_sr_ff   <= round_sat(m_sr_ff);
         o_si_ff   <= round_sat(m_si_ff);
         o_dr_ff   <= round_sat(m_dr_ff);
         o_di_ff   <= round_sat(m_di_ff);
         o_last_ff <= last_ff;
      end
   end

   assign sum_real  = o_sr_ff;
   assign sum_imag  = o_si_ff;
   assign diff_real = o_dr_ff;
   assign diff_imag = o_di_ff;
   assign out_last  = o_last_ff;

endmodule

FILE: hw/rtl/fft2_ctrl.sv
// ----------------------------------------------------------------------------
// fft2_ctrl
// Sequencer for one butterfly word at a time and the output register valid.
// ----------------------------------------------------------------------------
module fft2_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fft2_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      MULT,
      SUM,
      SCALE,
      OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = MULT;
            end
         end
         MULT: begin
            cmd.mult = 1'b1;
            state_in = SUM;
         end
         SUM: begin
            cmd.sum  = 1'b1;
            state_in = SCALE;
         end
         SCALE: begin
            cmd.scale = 1'b1;
            state_in  = OUTPUT;
         end
         OUTPUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = out_valid_ff;

endmodule

FILE: hw/rtl/radix2_fft_butterfly_stage.sv
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_stage
// Each word is walked by the sequencer through ROM read, b*W multiply, sum,
// 1/sqrt2 scale and round/saturate; a new word is accepted only after the last
// one is loaded into the output register, and that load waits for a free slot.
// The output register lets the next word enter while a result waits.
// Reset: synchronous; clears twiddle index, sequencer and output valid.
// ----------------------------------------------------------------------------
module radix2_fft_butterfly_stage #(
   parameter int TRANSFORM_SIZE  = 1024,
   parameter int TWIDDLE_ENTRIES = 512,
   parameter int SAMPLE_BITS     = 16
) (
   input  logic       clock,
   input  logic       reset,
   fft2_req_if.sink   req,
   fft2_rsp_if.source rsp
);

   fft2_pkg::cmd_type cmd;

   fft2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   fft2_datapath #(
      .TRANSFORM_SIZE  (TRANSFORM_SIZE),
      .TWIDDLE_ENTRIES (TWIDDLE_ENTRIES),
      .SAMPLE_BITS     (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .a_real     (req.a_real),
      .a_imag     (req.a_imag),
      .b_real     (req.b_real),
      .b_imag     (req.b_imag),
      .frame_last (req.frame_last),
      .sum_real   (rsp.sum_real),
      .sum_imag   (rsp.sum_imag),
      .diff_real  (rsp.diff_real),
      .diff_imag  (rsp.diff_imag),
      .out_last   (rsp.out_last)
   );

endmodule
